@@ rtl/rgbss_pkg.sv @@
`timescale 1ns / 1ps

package rgbss_pkg;

  // one color triple, red first
  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } in_req_t;

  // one serial bit for the display shift chain
  typedef struct packed {
    logic serial_data_level;
    logic latch_after;
  } out_req_t;

  localparam int unsigned SerialBits  = 64;
  localparam int unsigned ChannelBits = 21;
  localparam int unsigned SegBits     = 7;
  localparam int unsigned BitCntW     = $clog2(SerialBits);
  localparam int unsigned FifoDepth   = 2;

  typedef logic [SerialBits-1:0]  pattern_t;
  typedef logic [ChannelBits-1:0] chan_code_t;
  typedef logic [SegBits-1:0]     seg_code_t;

  // E shown for a digit above nine
  localparam seg_code_t SegError = 7'h7C;

  // segment codes for the custom wiring, digits zero to nine
  localparam seg_code_t SegCodes [10] = '{
    7'h6F, 7'h03, 7'h76, 7'h37, 7'h1B, 7'h3D, 7'h7D, 7'h07, 7'h7F, 7'h3F
  };

  localparam logic [BitCntW-1:0] LastBit = BitCntW'(SerialBits - 1);

  function automatic seg_code_t digit_code(input logic [3:0] digit);
    seg_code_t code;
    if (digit < 4'd10) begin
      code = SegCodes[digit];
    end else begin
      code = SegError;
    end
    return code;
  endfunction

  // byte to three segment codes: hundreds, tens, ones
  function automatic chan_code_t channel_code(input logic [7:0] level);
    logic [3:0]  hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  ones;
    if (level >= 8'd200) begin
      hund = 4'd2;
      rem  = 7'(level - 8'd200);
    end else if (level >= 8'd100) begin
      hund = 4'd1;
      rem  = 7'(level - 8'd100);
    end else begin
      hund = 4'd0;
      rem  = level[6:0];
    end
    // rem / 10 by reciprocal, exact for rem below 100
    prod     = 15'(rem) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    ones     = 4'(rem - tens_x10);
    return {digit_code(hund), digit_code(tens), digit_code(ones)};
  endfunction

endpackage

@@ rtl/rgbss_front.sv @@
`timescale 1ns / 1ps

module rgbss_front (
  input  rgbss_pkg::in_req_t  in_req_i,
  output rgbss_pkg::pattern_t pattern_o
);
  import rgbss_pkg::*;

  chan_code_t red_code;
  chan_code_t green_code;
  chan_code_t blue_code;

  assign red_code   = channel_code(in_req_i.red_level);
  assign green_code = channel_code(in_req_i.green_level);
  assign blue_code  = channel_code(in_req_i.blue_level);

  // red in the top bits, bit 0 stays low
  assign pattern_o = {red_code, green_code, blue_code, 1'b0};

endmodule

@@ rtl/rgbss_fifo.sv @@
`timescale 1ns / 1ps

module rgbss_fifo #(
  parameter int unsigned Depth = rgbss_pkg::FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  rgbss_pkg::pattern_t wr_data_i,
  output logic                full_o,
  input  logic                rd_i,
  output logic                valid_o,
  output rgbss_pkg::pattern_t rd_data_o
);
  import rgbss_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  pattern_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("pattern queue count beyond depth");
`endif

endmodule

@@ rtl/rgbss_back.sv @@
`timescale 1ns / 1ps

module rgbss_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  rgbss_pkg::pattern_t  q_data_i,
  output logic                 q_rd_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output rgbss_pkg::out_req_t  out_req_o
);
  import rgbss_pkg::*;

  pattern_t           shift_q, shift_d;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic               busy_q, busy_d;
  logic               take;
  logic               at_last;

  assign at_last = (bit_q == LastBit);
  assign take    = busy_q && pop_i;
  // next pattern loads when idle or when its predecessor's last bit leaves
  assign q_rd_o  = q_valid_i && (!busy_q || (take && at_last));

  always_comb begin
    shift_d = shift_q;
    bit_d   = bit_q;
    busy_d  = busy_q;
    if (q_rd_o) begin
      shift_d = q_data_i;
      bit_d   = '0;
      busy_d  = 1'b1;
    end else if (take) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        shift_d = shift_q >> 1;
        bit_d   = bit_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      bit_q  <= bit_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign empty_o                     = !busy_q;
  assign out_req_o.serial_data_level = ~shift_q[0];
  assign out_req_o.latch_after       = at_last;

`ifndef ASSERT_OFF
  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |-> (!busy_q || (pop_i && at_last)))
    else $error("pattern loaded while a frame is still shifting");

  a_bit_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !at_last) |=> (busy_q && bit_q == $past(bit_q) + 1'b1))
    else $error("bit counter did not advance on request");

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> ($past(at_last) && $past(pop_i)))
    else $error("frame ended before its last bit");
`endif

endmodule

@@ rtl/rgb_decimal_segment_serializer_top.sv @@
`timescale 1ns / 1ps

// rgb decimal segment serializer: each request on the input side carries one
// red, green and blue byte; every byte is split into hundreds, tens and ones
// digits, each digit mapped to a 7-bit segment code for the custom display
// wiring (E for a digit above nine), and the nine codes are packed red first
// into bits 63..1 of a frame with bit 0 low. The frame then leaves as 64
// result requests, bit 0 first, each carrying the inverted (active-low) data
// pin level; latch_after is high on the 64th so the display latch can pulse.
// Rate: one triple every 64 result pops, set by the output shifter, which
// moves one bit per cycle while pop is held; the encode is combinational at
// push and a small pattern queue (FifoDepth frames) lets new triples be
// pushed while a frame still shifts. With the shifter idle, a pushed frame is
// registered in the pattern queue and then in the shifter before it shows.

module rgb_decimal_segment_serializer_top #(
  parameter int unsigned FifoDepth = rgbss_pkg::FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input queue side
  input  logic                push,
  output logic                full,
  input  rgbss_pkg::in_req_t  in_req_i,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output rgbss_pkg::out_req_t out_req_o
);
  import rgbss_pkg::*;

  pattern_t enc_pattern;
  pattern_t q_data;
  logic     q_valid;
  logic     q_rd;

  // front: combinational encode of the triple into the 64-bit frame
  rgbss_front u_front (
    .in_req_i  (in_req_i),
    .pattern_o (enc_pattern)
  );

  // decoupling queue between encoder and shifter
  rgbss_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (enc_pattern),
    .full_o    (full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_data_o (q_data)
  );

  // back: shifts one bit per pop request, lsb first
  rgbss_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_req_o (out_req_o)
  );

endmodule
